@@ rtl/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types, codes and pixel functions for the TGA pixel RLE decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    // Input beat actions.
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_PULL  = 2'd1;
    localparam logic [1:0] ACT_PALW  = 2'd2;
    localparam logic [1:0] ACT_START = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEPTH    = 2'd0;
    localparam logic [1:0] CFG_COMPRESS = 2'd1;
    localparam logic [1:0] CFG_DITHER   = 2'd2;
    localparam logic [1:0] CFG_RGBA     = 2'd3;

    // Depth codes.
    localparam logic [1:0] DEPTH_PAL = 2'd0;
    localparam logic [1:0] DEPTH_16  = 2'd1;
    localparam logic [1:0] DEPTH_24  = 2'd2;
    localparam logic [1:0] DEPTH_32  = 2'd3;

    // Pixel constants.
    localparam logic [15:0] KEY_555    = 16'd31775;
    localparam logic [15:0] PACK_MASK  = 16'd65503;
    localparam logic [7:0]  ALPHA_MIN  = 8'd100;
    localparam logic [7:0]  MAX_RUN    = 8'd128;

    // Queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // 4x4 ordered dither matrix, indexed [x][y].
    localparam logic [3:0] DITHER_TAB [4][4] = '{
        '{4'd4,  4'd12, 4'd6,  4'd14},
        '{4'd10, 4'd0,  4'd8,  4'd2},
        '{4'd7,  4'd15, 4'd5,  4'd13},
        '{4'd9,  4'd3,  4'd11, 4'd1}
    };

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [1:0] dither_x;
        logic [1:0] dither_y;
        logic [7:0] pal_index;
        logic [7:0] pal_red;
        logic [7:0] pal_green;
        logic [7:0] pal_blue;
    } in_item_t;

    typedef struct packed {
        logic [15:0] packed_colour;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  run_left;
    } out_item_t;

    typedef struct packed {
        logic [1:0] depth_code;
        logic       compressed;
        logic       dither_enable;
        logic       rgba_mode;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_PULL,
        OP_PALW
    } q_op_t;

    // One queued command: a complete pixel, a run pull or a palette write.
    // For a palette write the entry index rides in pix[0].
    typedef struct packed {
        q_op_t           op;
        logic [3:0][7:0] pix;
        logic [1:0]      dx;
        logic [1:0]      dy;
        logic [7:0]      left;
        logic            store_run;
        logic [23:0]     pal_rgb;
    } q_item_t;

    // Decode the bytes of a complete pixel into {r, g, b, a}.
    function automatic logic [31:0] decode_pixel(
        input logic [1:0]      depth,
        input logic            rgba,
        input logic [3:0][7:0] bv,
        input logic [23:0]     pal_rgb,
        input logic            pal_ok
    );
        logic [7:0] r, g, b, a;
        logic       key, zero;
        r    = 8'd0;
        g    = 8'd0;
        b    = 8'd0;
        a    = 8'd255;
        key  = 1'b1;
        zero = 1'b0;
        unique case (depth)
            DEPTH_PAL: begin
                if (pal_ok) begin
                    r = pal_rgb[23:16];
                    g = pal_rgb[15:8];
                    b = pal_rgb[7:0];
                end
            end
            DEPTH_16: begin
                zero = rgba && ({bv[1], bv[0]} == KEY_555);
                r = {bv[1][6:0], 1'b0};
                g = {2'b00, bv[0][7:5], 3'b000} + {bv[1][1:0], 6'b000000};
                b = {bv[0][4:0], 3'b000};
            end
            DEPTH_24: begin
                b = bv[0];
                g = bv[1];
                r = bv[2];
            end
            default: begin
                b   = bv[0];
                g   = bv[1];
                r   = bv[2];
                key = 1'b0;
                if (rgba) begin
                    a = bv[3];
                end else if (bv[3] < ALPHA_MIN) begin
                    r = 8'd255;
                    g = 8'd0;
                    b = 8'd255;
                end
            end
        endcase
        if (rgba && key && r == 8'd255 && g == 8'd0 && b == 8'd255) begin
            zero = 1'b1;
        end
        return zero ? 32'd0 : {r, g, b, a};
    endfunction

    // Add with saturation at full scale.
    function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [3:0] d);
        logic [8:0] t;
        t = {1'b0, c} + {5'd0, d};
        return t[8] ? 8'd255 : t[7:0];
    endfunction

    // Build a result beat from a decoded colour.
    function automatic out_item_t make_result(
        input logic [31:0] col,
        input cfg_t        cfg,
        input logic [1:0]  dx,
        input logic [1:0]  dy,
        input logic [7:0]  left
    );
        out_item_t  o;
        logic [7:0] dr, dg, db;
        logic [3:0] t;
        o.red      = col[31:24];
        o.green    = col[23:16];
        o.blue     = col[15:8];
        o.alpha    = col[7:0];
        o.run_left = left;
        t  = DITHER_TAB[dx][dy];
        dr = o.red;
        dg = o.green;
        db = o.blue;
        if (cfg.dither_enable) begin
            dr = sat_add(o.red, t);
            dg = sat_add(o.green, {1'b0, t[3:1]});
            db = sat_add(o.blue, t);
        end
        o.packed_colour = cfg.rgba_mode ? 16'd0 :
                          ({dr[7:3], dg[7:2], db[7:3]} & PACK_MASK);
        return o;
    endfunction

endpackage

@@ rtl/tgarle_front.sv @@
// ----------------------------------------------------------------------------
// tgarle_front
// Accepts input beats, parses packet headers, gathers pixel bytes and
// queues complete pixels, run pulls and palette writes for the back end.
// ----------------------------------------------------------------------------
module tgarle_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tgarle_pkg::cfg_t     cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tgarle_pkg::in_item_t s_data,
    input  logic                 q_full,
    output logic                 q_push,
    output tgarle_pkg::q_item_t  q_item
);
    import tgarle_pkg::*;

    logic [7:0]      packet_left_reg, packet_left_next;
    logic            run_packet_reg, run_packet_next;
    logic            run_ready_reg, run_ready_next;
    logic [2:0][7:0] byte_buffer_reg, byte_buffer_next;
    logic [1:0]      byte_count_reg, byte_count_next;
    logic            accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the beat and update the packet state.
    always_comb begin
        packet_left_next = packet_left_reg;
        run_packet_next  = run_packet_reg;
        run_ready_next   = run_ready_reg;
        byte_buffer_next = byte_buffer_reg;
        byte_count_next  = byte_count_reg;
        q_push           = 1'b0;
        q_item           = '0;
        q_item.op        = OP_PIXEL;
        q_item.dx        = s_data.dither_x;
        q_item.dy        = s_data.dither_y;
        q_item.pal_rgb   = {s_data.pal_red, s_data.pal_green, s_data.pal_blue};
        // Byte 0 comes from the buffer whenever the pixel spans more bytes.
        q_item.pix[0]    = (cfg.depth_code != DEPTH_PAL) ? byte_buffer_reg[0] :
                                                           s_data.data_byte;
        q_item.pix[1]    = (cfg.depth_code > 2'd1) ? byte_buffer_reg[1] : s_data.data_byte;
        q_item.pix[2]    = (cfg.depth_code > 2'd2) ? byte_buffer_reg[2] : s_data.data_byte;
        q_item.pix[3]    = s_data.data_byte;
        if (accept) begin
            unique case (s_data.action)
                ACT_START: begin
                    packet_left_next = 8'd0;
                    run_packet_next  = 1'b0;
                    run_ready_next   = 1'b0;
                    byte_buffer_next = '0;
                    byte_count_next  = 2'd0;
                end
                ACT_PALW: begin
                    q_push        = 1'b1;
                    q_item.op     = OP_PALW;
                    q_item.pix[0] = s_data.pal_index;
                end
                ACT_PULL: begin
                    if (run_packet_reg && run_ready_reg && packet_left_reg != 8'd0) begin
                        packet_left_next = packet_left_reg - 8'd1;
                        q_push           = 1'b1;
                        q_item.op        = OP_PULL;
                        q_item.left      = packet_left_reg - 8'd1;
                    end
                end
                default: begin
                    if (cfg.compressed && packet_left_reg == 8'd0) begin
                        // Packet header.
                        byte_count_next  = 2'd0;
                        byte_buffer_next = '0;
                        run_ready_next   = 1'b0;
                        run_packet_next  = s_data.data_byte[7];
                        packet_left_next = s_data.data_byte[7] ?
                                           (s_data.data_byte - 8'd127) :
                                           (s_data.data_byte + 8'd1);
                    end else if (cfg.compressed && run_packet_reg && run_ready_reg) begin
                        // Loaded run: the byte is dropped.
                    end else if (byte_count_reg < cfg.depth_code) begin
                        byte_buffer_next[byte_count_reg] = s_data.data_byte;
                        byte_count_next                  = byte_count_reg + 2'd1;
                    end else begin
                        // Last byte of a pixel.
                        byte_buffer_next = '0;
                        byte_count_next  = 2'd0;
                        q_push           = 1'b1;
                        if (cfg.compressed) begin
                            packet_left_next = packet_left_reg - 8'd1;
                            if (run_packet_reg) begin
                                run_ready_next   = 1'b1;
                                q_item.store_run = 1'b1;
                                q_item.left      = packet_left_reg - 8'd1;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_left_reg <= 8'd0;
            run_packet_reg  <= 1'b0;
            run_ready_reg   <= 1'b0;
            byte_buffer_reg <= '0;
            byte_count_reg  <= 2'd0;
        end else begin
            packet_left_reg <= packet_left_next;
            run_packet_reg  <= run_packet_next;
            run_ready_reg   <= run_ready_next;
            byte_buffer_reg <= byte_buffer_next;
            byte_count_reg  <= byte_count_next;
        end
    end

    // A packet never holds more than a full run.
    a_packet_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        packet_left_reg <= MAX_RUN)
        else $error("packet count above maximum run length");

endmodule

@@ rtl/tgarle_fifo.sv @@
// ----------------------------------------------------------------------------
// tgarle_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tgarle_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tgarle_pkg::q_item_t push_item,
    input  logic                pop,
    output tgarle_pkg::q_item_t pop_item,
    output logic                empty,
    output logic                full
);
    import tgarle_pkg::*;

    q_item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign empty    = (count_reg == QCNT_W'(0));
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_item = entries_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from an empty queue");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count did not follow a push");

endmodule

@@ rtl/tgarle_back.sv @@
// ----------------------------------------------------------------------------
// tgarle_back
// Carries out queued commands: palette writes and reads, pixel decode,
// run colour storage, dither and RGB565 packing into the output register.
// ----------------------------------------------------------------------------
module tgarle_back #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tgarle_pkg::cfg_t      cfg,
    input  logic                  q_empty,
    input  tgarle_pkg::q_item_t   q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tgarle_pkg::out_item_t m_data
);
    import tgarle_pkg::*;

    localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [23:0]       pal_mem [PALETTE_ENTRIES];
    logic [23:0]       pal_rd_reg;
    logic              s1_valid_reg, s1_valid_next;
    q_item_t           s1_item_reg;
    logic              s1_pal_ok_reg;
    logic [31:0]       run_colour_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;
    logic              out_free;
    logic              s1_free;
    logic              idx_ok;
    logic [PAL_AW-1:0] pal_addr;
    logic [31:0]       pix_colour;
    logic [31:0]       colour;
    logic              s1_move;

    // Handshake between the queue, the decode stage and the output register.
    assign out_free = !out_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign q_pop    = !q_empty && s1_free;
    assign s1_move  = s1_valid_reg && out_free;
    assign idx_ok   = ({1'b0, q_item.pix[0]} < 9'(PALETTE_ENTRIES));
    assign pal_addr = q_item.pix[0][PAL_AW-1:0];

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_free) begin
            s1_valid_next = q_pop && (q_item.op != OP_PALW);
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Palette memory: one write or one registered read per popped beat.
    always_ff @(posedge aclk) begin
        if (q_pop && q_item.op == OP_PALW && idx_ok) begin
            pal_mem[pal_addr] <= q_item.pal_rgb;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_item.op != OP_PALW) begin
            pal_rd_reg    <= pal_mem[pal_addr];
            s1_item_reg   <= q_item;
            s1_pal_ok_reg <= idx_ok;
        end
    end

    // Decode stage; a pull reuses the stored run colour.
    assign pix_colour = decode_pixel(cfg.depth_code, cfg.rgba_mode, s1_item_reg.pix,
                                     pal_rd_reg, s1_pal_ok_reg);
    assign colour     = (s1_item_reg.op == OP_PULL) ? run_colour_reg : pix_colour;

    always_ff @(posedge aclk) begin
        if (s1_move && s1_item_reg.op == OP_PIXEL && s1_item_reg.store_run) begin
            run_colour_reg <= pix_colour;
        end
        if (s1_move) begin
            out_item_reg <= make_result(colour, cfg, s1_item_reg.dx, s1_item_reg.dy,
                                        s1_item_reg.left);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

@@ rtl/tga_pixel_rle_decoder.sv @@
// ----------------------------------------------------------------------------
// tga_pixel_rle_decoder
// TGA pixel stream decoder with run-length packets, palette, colour keying,
// ordered dither and RGB565 packing.
// ----------------------------------------------------------------------------
// The decoder takes one input beat per clock cycle unless the queue is full;
// a result passes the queue, the decode stage and the output register.
// Throughput is set by the single-port palette memory and the decode stage,
// each of which handles one command per cycle unless the output stalls; a
// four-entry queue between the header parser and the decode stage lets
// either side stall alone, and the output register lets a new beat enter
// while a result waits on m_ready. The palette is not cleared at reset, so
// entries must be written before pixels use them. Configuration writes take
// effect at the next clock edge and belong in idle time between images.
module tga_pixel_rle_decoder #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [1:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tgarle_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tgarle_pkg::out_item_t m_data
);
    import tgarle_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    q_push, q_pop, q_empty, q_full;
    q_item_t q_in_item, q_out_item;

    // Configuration registers.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEPTH:    cfg_next.depth_code    = cfg_wdata;
                CFG_COMPRESS: cfg_next.compressed    = cfg_wdata[0];
                CFG_DITHER:   cfg_next.dither_enable = cfg_wdata[0];
                default:      cfg_next.rgba_mode     = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_code    <= DEPTH_24;
            cfg_reg.compressed    <= 1'b0;
            cfg_reg.dither_enable <= 1'b0;
            cfg_reg.rgba_mode     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tgarle_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in_item)
    );

    tgarle_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    tgarle_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_item  (q_out_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TGA pixel RLE decoder. A scoreboard class keeps
// its own copy of the decoder state and configuration, predicts the result
// beat, if any, of every accepted input beat and checks the result beats in
// order. Stimulus is a short directed run followed by random phases over
// every depth, compression and RGBA mode, random input gaps and result stalls.
// ----------------------------------------------------------------------------
import tgarle_pkg::*;

class pixel_scoreboard;
    cfg_t        cfg;
    logic [7:0]  packet_left;
    logic        run_packet;
    logic        run_ready;
    logic [31:0] run_colour;
    logic [31:0] byte_buffer;
    logic [1:0]  byte_count;
    logic [23:0] palette [256];
    out_item_t   pixels_due [$];
    int          errors;
    int          applied;

    function new();
        cfg = '{depth_code: DEPTH_24, compressed: 1'b0, dither_enable: 1'b0,
                rgba_mode: 1'b0};
        run_colour = '0;
        errors     = 0;
        applied    = 0;
        clear_packet();
    endfunction

    // Packet and pixel assembly state goes back to the start of an image.
    function void clear_packet();
        packet_left = '0;
        run_packet  = 1'b0;
        run_ready   = 1'b0;
        byte_buffer = '0;
        byte_count  = '0;
    endfunction

    // Mirror of one register write.
    function void set_reg(logic [1:0] idx, logic [1:0] val);
        case (idx)
            CFG_DEPTH:    cfg.depth_code    = val;
            CFG_COMPRESS: cfg.compressed    = val[0];
            CFG_DITHER:   cfg.dither_enable = val[0];
            CFG_RGBA:     cfg.rgba_mode     = val[0];
            default: ;
        endcase
    endfunction

    function logic [7:0] clip8(int v);
        return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    // Turn the bytes of one complete pixel into {red, green, blue, alpha}.
    function logic [31:0] unpack_colour(logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2, logic [7:0] b3);
        logic [7:0] r, g, b, a;
        bit         keyed;
        r     = 8'd0;
        g     = 8'd0;
        b     = 8'd0;
        a     = 8'hFF;
        keyed = 1'b1;
        case (cfg.depth_code)
            DEPTH_PAL: begin
                {r, g, b} = palette[b0];
            end
            DEPTH_16: begin
                if (cfg.rgba_mode && {b1, b0} == KEY_555) return 32'd0;
                r = 8'((b1 & 8'h7F) << 1);
                g = 8'(((b0 & 8'hE0) >> 2) + (b1 << 6));
                b = 8'((b0 & 8'h1F) << 3);
            end
            DEPTH_24: begin
                {r, g, b} = {b2, b1, b0};
            end
            default: begin
                {r, g, b} = {b2, b1, b0};
                keyed = 1'b0;
                if (cfg.rgba_mode) begin
                    a = b3;
                end else if (b3 < ALPHA_MIN) begin
                    {r, g, b} = 24'hFF00FF;
                end
            end
        endcase
        if (cfg.rgba_mode && keyed && {r, g, b} == 24'hFF00FF) return 32'd0;
        return {r, g, b, a};
    endfunction

    // Build the result beat for a decoded colour under the current setting.
    function out_item_t form_pixel(logic [31:0] col, logic [1:0] dx, logic [1:0] dy,
                                   logic [7:0] left);
        out_item_t  o;
        int         t;
        logic [7:0] dr, dg, db;
        {o.red, o.green, o.blue, o.alpha} = col;
        o.run_left = left;
        dr = o.red;
        dg = o.green;
        db = o.blue;
        if (cfg.dither_enable) begin
            t  = DITHER_TAB[dx][dy];
            dr = clip8(o.red + t);
            dg = clip8(o.green + t / 2);
            db = clip8(o.blue + t);
        end
        o.packed_colour = cfg.rgba_mode ? 16'd0 :
                          ({dr[7:3], dg[7:2], db[7:3]} & PACK_MASK);
        return o;
    endfunction

    // Apply one accepted input beat and queue the pixel it causes, if any.
    function void note_beat(in_item_t it);
        int          need;
        logic [7:0]  bv [4];
        logic [31:0] col;
        case (it.action)
            ACT_START: begin
                clear_packet();
                applied++;
                return;
            end
            ACT_PALW: begin
                palette[it.pal_index] = {it.pal_red, it.pal_green, it.pal_blue};
                applied++;
                return;
            end
            ACT_PULL: begin
                if (run_packet && run_ready && packet_left != 0) begin
                    packet_left--;
                    pixels_due.push_back(form_pixel(run_colour, it.dither_x,
                                                    it.dither_y, packet_left));
                    applied++;
                end
                return;
            end
            default: ;
        endcase

        // Packet header, or a byte that a loaded run swallows.
        if (cfg.compressed) begin
            if (packet_left == 0) begin
                byte_count  = '0;
                byte_buffer = '0;
                run_ready   = 1'b0;
                run_packet  = it.data_byte[7];
                packet_left = it.data_byte[7] ? 8'(it.data_byte - 8'd127)
                                              : 8'(it.data_byte + 8'd1);
                applied++;
                return;
            end
            if (run_packet && run_ready) return;
        end

        applied++;
        need = int'(cfg.depth_code) + 1;
        if (int'(byte_count) + 1 < need) begin
            byte_buffer[int'(byte_count) * 8 +: 8] = it.data_byte;
            byte_count++;
            return;
        end
        for (int i = 0; i < 4; i++) begin
            bv[i] = (i + 1 < need) ? byte_buffer[i * 8 +: 8] : it.data_byte;
        end
        byte_buffer = '0;
        byte_count  = '0;
        col = unpack_colour(bv[0], bv[1], bv[2], bv[3]);
        if (!cfg.compressed) begin
            pixels_due.push_back(form_pixel(col, it.dither_x, it.dither_y, 8'd0));
            return;
        end
        packet_left--;
        if (run_packet) begin
            run_colour = col;
            run_ready  = 1'b1;
            pixels_due.push_back(form_pixel(col, it.dither_x, it.dither_y, packet_left));
        end else begin
            pixels_due.push_back(form_pixel(col, it.dither_x, it.dither_y, 8'd0));
        end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // Check one result beat against the oldest predicted pixel.
    function void check_pixel(out_item_t got);
        out_item_t want;
        if (pixels_due.size() == 0) begin
            $error("result beat with no pixel predicted: %h", got);
            errors++;
            return;
        end
        want = pixels_due.pop_front();
        compare_field("packed_colour", want.packed_colour, got.packed_colour);
        compare_field("red", want.red, got.red);
        compare_field("green", want.green, got.green);
        compare_field("blue", want.blue, got.blue);
        compare_field("alpha", want.alpha, got.alpha);
        compare_field("run_left", want.run_left, got.run_left);
    endfunction
endclass

module testbench;
    localparam int unsigned LIMIT = 400000;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [1:0] cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_data;

    pixel_scoreboard sb = new();
    int unsigned     cycles = 0;
    bit              hold_req = 1'b0;
    int              pal_known [$];
    logic [7:0]      tpl [4];

    tga_pixel_rle_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Every accepted result beat is checked.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_pixel(m_data);
    end

    // Result side: random stalls, quiet stretches and one long hold-off.
    initial begin : result_sink
        int roll;
        int hold;
        bit held_long;
        hold      = 0;
        held_long = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held_long) begin
                held_long = 1'b1;
                hold      = 300;
            end else if (hold == 0 && (cycles / 3000) % 4 != 1) begin
                roll = $urandom_range(0, 99);
                if (roll < 15) hold = $urandom_range(1, 3);
                else if (roll < 18) hold = $urandom_range(10, 40);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // An input beat with the given action and byte; other fields are random.
    function automatic in_item_t beat(logic [1:0] act, logic [7:0] data);
        in_item_t it;
        it.action    = act;
        it.data_byte = data;
        it.dither_x  = 2'($urandom);
        it.dither_y  = 2'($urandom);
        {it.pal_index, it.pal_red, it.pal_green, it.pal_blue} = $urandom;
        return it;
    endfunction

    function automatic in_item_t pal_beat(logic [7:0] idx, logic [23:0] rgb);
        in_item_t it;
        it = beat(ACT_PALW, 8'($urandom));
        it.pal_index = idx;
        {it.pal_red, it.pal_green, it.pal_blue} = rgb;
        return it;
    endfunction

    // Next stream byte: headers if compressed and no packet open, else pixel bytes
    // from a per-pixel pattern. Palette pixels only use entries already written.
    function automatic logic [7:0] stream_byte(bit loaded);
        int         roll;
        logic [7:0] v;
        roll = $urandom_range(0, 99);
        if (sb.cfg.compressed && sb.packet_left == 0) begin
            if (roll < 1) return 8'd255;
            if (roll < 2) return 8'd127;
            if (roll < 5) return 8'($urandom);
            if (roll < 52) return 8'(128 + $urandom_range(0, 5));
            return 8'($urandom_range(0, 5));
        end
        if (sb.cfg.compressed && loaded) return 8'($urandom);
        if (sb.byte_count == 0) begin
            foreach (tpl[i]) tpl[i] = 8'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    tpl[0] = 8'h1F;
                    tpl[1] = 8'h7C;
                end
                1: begin
                    tpl[0] = 8'hFF;
                    tpl[1] = 8'h00;
                    tpl[2] = 8'hFF;
                end
                2: tpl[3] = 8'($urandom_range(97, 102));
                3: foreach (tpl[i]) tpl[i] = 8'($urandom_range(244, 255));
                default: ;
            endcase
        end
        v = tpl[sb.byte_count];
        if (sb.cfg.depth_code == DEPTH_PAL) begin
            v = 8'(pal_known[$urandom_range(0, pal_known.size() - 1)]);
        end
        return v;
    endfunction

    // Random beat, mostly well-formed for the current packet state.
    function automatic in_item_t next_beat();
        int roll;
        bit loaded;
        roll   = $urandom_range(0, 99);
        loaded = sb.run_packet && sb.run_ready && sb.packet_left != 0;
        if (roll < 3) return beat(ACT_START, 8'($urandom));
        if (roll < 8) begin
            if ($urandom_range(0, 9) == 0) return pal_beat(8'($urandom), 24'hFF00FF);
            return pal_beat(8'($urandom), 24'($urandom));
        end
        if (roll < 11 || (loaded && roll < 92)) return beat(ACT_PULL, 8'($urandom));
        return beat(ACT_BYTE, stream_byte(loaded));
    endfunction

    // Offer one beat and hold it until accepted. Valid is left high so that a
    // following beat can go out on the next cycle.
    task automatic push_beat(input in_item_t it);
        s_data <= it;
        if (!s_valid) s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_beat(it);
        if (it.action == ACT_PALW) pal_known.push_back(it.pal_index);
    endtask

    task automatic idle_gap(input bit quiet);
        int n;
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65) n = 0;
        else if (roll < 93) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 40);
        if (n > 0) begin
            if (s_valid) s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every predicted pixel has come out and the
    // pipeline has had time to finish any beat that makes no result.
    task automatic settle();
        if (s_valid) s_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // Write all four registers; spare data bits of the flag registers are random.
    task automatic program_regs(input cfg_t c);
        cfg_write(CFG_DEPTH, c.depth_code);
        cfg_write(CFG_COMPRESS, {1'($urandom), c.compressed});
        cfg_write(CFG_DITHER, {1'($urandom), c.dither_enable});
        cfg_write(CFG_RGBA, {1'($urandom), c.rgba_mode});
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        cfg_t setting;
        int   mark;
        bit   quiet;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: a raw 24-bit magenta pixel on the packed path.
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'h00));
        push_beat(beat(ACT_BYTE, 8'hFF));

        // Palette pixels in RGBA mode, including a keyed entry and both index ends.
        settle();
        program_regs('{DEPTH_PAL, 1'b0, 1'b0, 1'b1});
        push_beat(pal_beat(8'd0, 24'hFF00FF));
        push_beat(pal_beat(8'd255, 24'hFFFFFF));
        push_beat(pal_beat(8'd90, 24'($urandom)));
        push_beat(beat(ACT_BYTE, 8'd0));
        push_beat(beat(ACT_BYTE, 8'd255));
        push_beat(beat(ACT_BYTE, 8'd90));

        // Compressed 16-bit: a keyed run of two with an ignored byte, a pull with
        // nothing left, a raw packet of one and a start of image.
        settle();
        program_regs('{DEPTH_16, 1'b1, 1'b0, 1'b1});
        push_beat(beat(ACT_BYTE, 8'h81));
        push_beat(beat(ACT_BYTE, 8'h1F));
        push_beat(beat(ACT_BYTE, 8'h7C));
        push_beat(beat(ACT_BYTE, 8'h55));
        push_beat(beat(ACT_PULL, 8'h00));
        push_beat(beat(ACT_PULL, 8'h00));
        push_beat(beat(ACT_BYTE, 8'h00));
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_START, 8'h00));

        // Raw 32-bit with dither: alpha just below and at the threshold.
        settle();
        program_regs('{DEPTH_32, 1'b0, 1'b1, 1'b0});
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'd99));
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'hFF));
        push_beat(beat(ACT_BYTE, 8'd100));

        // Random phases over every depth, packing mode and output path.
        for (int ph = 0; ph < 16; ph++) begin
            settle();
            setting.depth_code    = 2'(ph % 4);
            setting.compressed    = 1'((ph / 4) % 2);
            setting.rgba_mode     = 1'(ph / 8);
            setting.dither_enable = 1'(((ph % 4) + (ph / 4)) % 2);
            program_regs(setting);
            quiet = (ph % 5 == 2);
            mark  = sb.applied;
            while (sb.applied < mark + 40) begin
                if (ph == 1 && sb.applied == mark + 8) hold_req = 1'b1;
                if (ph == 6 && sb.applied == mark + 20) settle();
                idle_gap(quiet);
                push_beat(next_beat());
            end
        end

        settle();
        if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/tgarle_pkg.sv
rtl/tgarle_front.sv
rtl/tgarle_fifo.sv
rtl/tgarle_back.sv
rtl/tga_pixel_rle_decoder.sv
sim/testbench.sv
